/* hw/rtl/hmf_pkg.sv */
// ----------------------------------------------------------------------------
// hmf_pkg
// shared types, constants and the keyword table of the message framer
// ----------------------------------------------------------------------------
package hmf_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int BODY_W          = 32;
  localparam int KW_LEN          = 15;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    VP_NO_KEYWORD = 2'd0,
    VP_SKIP_BLANK = 2'd1,
    VP_DIGITS     = 2'd2,
    VP_DONE       = 2'd3
  } value_phase_t;

  typedef enum logic [1:0] {
    DP_NONE    = 2'd0,
    DP_CR      = 2'd1,
    DP_CRLF    = 2'd2,
    DP_CRLFCR  = 2'd3
  } delim_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              header_done;
    logic              message_end;
    logic [BODY_W-1:0] body_bytes;
  } result_t;

  // "Content-Length:"
  function automatic logic [7:0] keyword_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/hmf_byte_if.sv */
// ----------------------------------------------------------------------------
// hmf_byte_if
// valid/ready channel carrying one raw stream byte per transaction
// ----------------------------------------------------------------------------
interface hmf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* hw/rtl/hmf_result_if.sv */
// ----------------------------------------------------------------------------
// hmf_result_if
// valid/ready channel carrying one framed byte and its markers per transaction
// ----------------------------------------------------------------------------
interface hmf_result_if
  import hmf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              header_done;
  logic              message_end;
  logic [BODY_W-1:0] body_bytes;

  modport source (output valid, output out_byte, output header_done,
                  output message_end, output body_bytes, input ready);
  modport sink   (input valid, input out_byte, input header_done,
                  input message_end, input body_bytes, output ready);
endinterface

/* hw/rtl/hmf_parser.sv */
// ----------------------------------------------------------------------------
// hmf_parser
// per-byte header matchers, length accumulator and body counter
// ----------------------------------------------------------------------------
module hmf_parser
  import hmf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  output result_t    res
);

  localparam int WW = LENGTH_BITS + 4;

  phase_t                 phase_r, phase_nxt;
  delim_t                 delim_r, delim_nxt;
  logic [3:0]             kw_r, kw_nxt;
  value_phase_t           vp_r, vp_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic                   digit;
  logic [WW-1:0]          acc_w;
  logic [WW-1:0]          mac;
  logic                   delim_hit;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS+BODY_W-1:0] len_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      delim_r <= DP_NONE;
      kw_r    <= '0;
      vp_r    <= VP_NO_KEYWORD;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      delim_r <= delim_nxt;
      kw_r    <= kw_nxt;
      vp_r    <= vp_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    digit     = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    acc_w     = WW'(acc_r);
    mac       = (acc_w << 3) + (acc_w << 1) + WW'(data_byte[3:0]);
    phase_nxt = phase_r;
    delim_nxt = delim_r;
    kw_nxt    = kw_r;
    vp_nxt    = vp_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    delim_hit = 1'b0;
    len       = '0;
    rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

    res.out_byte    = data_byte;
    res.header_done = 1'b0;
    res.message_end = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        // keyword and value scan
        case (vp_r)
          VP_NO_KEYWORD: begin
            if ((kw_r < 4'(KW_LEN)) && (keyword_char(kw_r) == data_byte)) begin
              kw_nxt = kw_r + 1'b1;
            end else if (data_byte == keyword_char(4'd0)) begin
              kw_nxt = 4'd1;
            end else begin
              kw_nxt = 4'd0;
            end
            if (kw_nxt == 4'(KW_LEN)) begin
              vp_nxt = VP_SKIP_BLANK;
            end
          end
          VP_SKIP_BLANK: begin
            if ((data_byte == CH_SPACE) || (data_byte == CH_TAB)) begin
              vp_nxt = VP_SKIP_BLANK;
            end else if (digit) begin
              acc_nxt = LENGTH_BITS'(data_byte[3:0]);
              vp_nxt  = VP_DIGITS;
            end else begin
              vp_nxt = VP_DONE;
            end
          end
          VP_DIGITS: begin
            if (digit) begin
              if (|mac[WW-1:LENGTH_BITS]) begin
                acc_nxt = '1;
              end else begin
                acc_nxt = mac[LENGTH_BITS-1:0];
              end
            end else begin
              vp_nxt = VP_DONE;
            end
          end
          default: begin
            vp_nxt = vp_r;
          end
        endcase

        // delimiter scan
        if (data_byte == CH_CR) begin
          delim_nxt = (delim_r == DP_CRLF) ? DP_CRLFCR : DP_CR;
        end else if (data_byte == CH_LF) begin
          if (delim_r == DP_CRLFCR) begin
            delim_nxt = DP_NONE;
            delim_hit = 1'b1;
          end else begin
            delim_nxt = (delim_r == DP_CR) ? DP_CRLF : DP_NONE;
          end
        end else begin
          delim_nxt = DP_NONE;
        end

        if (delim_hit) begin
          len             = acc_nxt;
          res.header_done = 1'b1;
          delim_nxt       = DP_NONE;
          kw_nxt          = '0;
          vp_nxt          = VP_NO_KEYWORD;
          acc_nxt         = '0;
          if (len == '0) begin
            res.message_end = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
            rem_nxt   = len;
          end
        end
      end
      PH_BODY: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          res.message_end = 1'b1;
          phase_nxt       = PH_HEADER;
          delim_nxt       = DP_NONE;
          kw_nxt          = '0;
          vp_nxt          = VP_NO_KEYWORD;
          acc_nxt         = '0;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    len_wide       = (LENGTH_BITS + BODY_W)'(len);
    res.body_bytes = len_wide[BODY_W-1:0];
  end

endmodule

/* hw/rtl/http_message_framer_core.sv */
// ----------------------------------------------------------------------------
// http_message_framer_core
// frames back-to-back http messages by content-length on a byte stream
// ----------------------------------------------------------------------------
// Every byte comes out unchanged with two markers: header_done on the final
// LF of the first CR LF CR LF of a header, together with the body length read
// from the first "Content-Length:" field (zero when absent, saturated at
// 2^LENGTH_BITS - 1, reported in 32 bits), and message_end on the last byte
// of each message. One byte is taken per clock cycle while out_if.ready does
// not stall the output; a byte taken passes through an input register and a
// result register before it is offered at the output, and the header
// matchers, the length accumulator and the body counter are updated as each
// byte moves from the input register into the result register.
module http_message_framer_core
  import hmf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hmf_byte_if.sink   in_if,
  hmf_result_if.source out_if
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic       advance;

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.data_byte;
    end
  end

  hmf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_valid_r && advance),
    .data_byte (in_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_byte    = out_r.out_byte;
  assign out_if.header_done = out_r.header_done;
  assign out_if.message_end = out_r.message_end;
  assign out_if.body_bytes  = out_r.body_bytes;

endmodule
